### design/btpc_pkg.sv
// ----------------------------------------------------------------------------
// btpc_pkg
// shared types, constants and helpers for the barometric compensation block
// ----------------------------------------------------------------------------
package btpc_pkg;

  localparam int unsigned CAL_W    = 48;
  localparam int unsigned DATA_W   = 64;
  localparam int unsigned ADDR_W   = 5;
  localparam int unsigned SAMPLE_W = 20;

  localparam logic [63:0] T_OFFSET = 64'd128000;
  localparam logic [20:0] P_BASE   = 21'd1048576;
  localparam logic [63:0] P_SCALE  = 64'd3125;
  localparam logic [63:0] ROUND    = 64'd128;
  localparam logic [63:0] P_BIAS   = 64'd1 << 47;

  localparam logic [1:0] REG_TEMP    = 2'd0;
  localparam logic [1:0] REG_PRESS_A = 2'd1;
  localparam logic [1:0] REG_PRESS_B = 2'd2;
  localparam logic [1:0] REG_PRESS_C = 2'd3;

  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
  } btpc_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] res;
  } btpc_rsp_t;

  function automatic logic [63:0] sx16(input logic [15:0] w);
    return {{48{w[15]}}, w};
  endfunction

  function automatic logic [63:0] asr(input logic [63:0] x, input int unsigned s);
    return 64'($signed(x) >>> s);
  endfunction

endpackage

### design/btpc_mul.sv
// ----------------------------------------------------------------------------
// btpc_mul
// low 64 bits of a 64x64 product from one 32x32 multiplier, reused over successive steps
// ----------------------------------------------------------------------------
module btpc_mul (
  input  logic                clk,
  input  logic                rst_n,
  input  btpc_pkg::btpc_req_t req,
  output btpc_pkg::btpc_rsp_t rsp
);
  import btpc_pkg::*;

  logic [63:0] a_r, b_r, acc_r, acc_nxt;
  logic [1:0]  step_r;
  logic        busy_r, done_r;
  logic [31:0] opa, opb;
  logic [63:0] prod;

  always_comb begin
    case (step_r)
      2'd0:    begin opa = a_r[31:0];  opb = b_r[31:0];  end
      2'd1:    begin opa = a_r[63:32]; opb = b_r[31:0];  end
      default: begin opa = a_r[31:0];  opb = b_r[63:32]; end
    endcase
    prod = {32'd0, opa} * {32'd0, opb};
    if (step_r == 2'd0) acc_nxt = prod;
    else acc_nxt = acc_r + {prod[31:0], 32'd0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= 2'd0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        a_r    <= req.a;
        b_r    <= req.b;
        step_r <= 2'd0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        acc_r  <= acc_nxt;
        step_r <= step_r + 2'd1;
        if (step_r == 2'd2) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.res  = acc_r;

endmodule

### design/btpc_div.sv
// ----------------------------------------------------------------------------
// btpc_div
// signed 64-bit restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module btpc_div (
  input  logic                clk,
  input  logic                rst_n,
  input  btpc_pkg::btpc_req_t req,
  output btpc_pkg::btpc_rsp_t rsp
);
  import btpc_pkg::*;

  logic [63:0] rem_r, quo_r, ub_r;
  logic [5:0]  cnt_r;
  logic        busy_r, done_r, neg_r;
  logic [64:0] rem_s, diff;

  assign rem_s = {rem_r, quo_r[63]};
  assign diff  = rem_s - {1'b0, ub_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 6'd0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        quo_r  <= req.a[63] ? 64'd0 - req.a : req.a;
        ub_r   <= req.b[63] ? 64'd0 - req.b : req.b;
        neg_r  <= req.a[63] ^ req.b[63];
        rem_r  <= 64'd0;
        cnt_r  <= 6'd0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= diff[64] ? rem_s[63:0] : diff[63:0];
        quo_r <= {quo_r[62:0], ~diff[64]};
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.res  = neg_r ? 64'd0 - quo_r : quo_r;

endmodule

### design/baro_temp_pressure_compensation_top.sv
// ----------------------------------------------------------------------------
// baro_temp_pressure_compensation_top
// integer temperature / pressure compensation on a shared multiplier
// ----------------------------------------------------------------------------
//  channel | direction | handshake         | payload
//  in      | input     | in_valid/in_stall | in_op, in_raw_sample
//  out     | output    | out_valid/out_stall | out_kind, out_value, out_divide_fault
//  cfg     | apb write | psel/penable/pwrite | paddr[4:3] index, 64-bit data
//
//  temperature word: three 64-bit products
//  pressure word: ten products plus the 64-step divider
//  a zero divisor ends the pressure word early with a fault
//  the multiplier forms each product on one 32x32 unit
//  reset clears calibration, fine temperature and the sequencer
//  a stalled result stays in the output register; the next word is taken
// ----------------------------------------------------------------------------
module baro_temp_pressure_compensation_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_op,
  input  logic [btpc_pkg::SAMPLE_W-1:0]  in_raw_sample,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_kind,
  output logic signed [31:0]             out_value,
  output logic                           out_divide_fault,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [btpc_pkg::ADDR_W-1:0]    cfg_paddr,
  input  logic [btpc_pkg::DATA_W-1:0]    cfg_pwdata,
  output logic [btpc_pkg::DATA_W-1:0]    cfg_prdata,
  output logic                           cfg_pready
);
  import btpc_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_T_MA, S_T_MB, S_T_MC, S_T_FIN,
    S_P_M1, S_P_M2, S_P_M3, S_P_M4, S_P_M5, S_P_M6, S_P_N,
    S_P_M7, S_P_DIV, S_P_M8, S_P_M9, S_P_M10, S_P_FIN, S_OUT
  } state_t;

  // calibration registers
  logic [CAL_W-1:0] tcal_r, pca_r, pcb_r, pcc_r;
  logic [1:0]       cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[4:3];

  always_comb begin
    case (cfg_idx)
      REG_TEMP:    cfg_prdata = {16'd0, tcal_r};
      REG_PRESS_A: cfg_prdata = {16'd0, pca_r};
      REG_PRESS_B: cfg_prdata = {16'd0, pcb_r};
      REG_PRESS_C: cfg_prdata = {16'd0, pcc_r};
      default:     cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tcal_r <= '0;
      pca_r  <= '0;
      pcb_r  <= '0;
      pcc_r  <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (cfg_idx)
        REG_TEMP:    tcal_r <= cfg_pwdata[CAL_W-1:0];
        REG_PRESS_A: pca_r  <= cfg_pwdata[CAL_W-1:0];
        REG_PRESS_B: pcb_r  <= cfg_pwdata[CAL_W-1:0];
        REG_PRESS_C: pcc_r  <= cfg_pwdata[CAL_W-1:0];
        default: ;
      endcase
    end
  end

  // calibration words
  logic [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
  assign t1 = {48'd0, tcal_r[15:0]};
  assign t2 = sx16(tcal_r[31:16]);
  assign t3 = sx16(tcal_r[47:32]);
  assign p1 = {48'd0, pca_r[15:0]};
  assign p2 = sx16(pca_r[31:16]);
  assign p3 = sx16(pca_r[47:32]);
  assign p4 = sx16(pcb_r[15:0]);
  assign p5 = sx16(pcb_r[31:16]);
  assign p6 = sx16(pcb_r[47:32]);
  assign p7 = sx16(pcc_r[15:0]);
  assign p8 = sx16(pcc_r[31:16]);
  assign p9 = sx16(pcc_r[47:32]);

  // sequencer state
  state_t         state_r;
  logic           issued_r;
  logic           op_r;
  logic [19:0]    adc_r;
  logic [63:0]    ra_r, rb_r, rc_r;
  logic [31:0]    ft_r;
  logic [31:0]    res_val_r;
  logic           res_fault_r;
  logic           out_valid_r, out_kind_r, out_fault_r;
  logic [31:0]    out_value_r;

  btpc_req_t mul_req, div_req;
  btpc_rsp_t mul_rsp, div_rsp;

  btpc_mul u_mul (.clk(clk), .rst_n(rst_n), .req(mul_req), .rsp(mul_rsp));
  btpc_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

  logic        is_mul;
  logic [63:0] ta, tb, tf5, pn, pfin;

  assign ta  = {47'd0, adc_r[19:3]} - {47'd0, tcal_r[15:0], 1'b0};
  assign tb  = {48'd0, adc_r[19:4]} - t1;
  assign tf5 = {ra_r[61:0], 2'b00} + ra_r + ROUND;
  assign pn  = {12'd0, P_BASE - {1'b0, adc_r}, 31'd0} - rb_r;
  assign pfin = asr(ra_r + rb_r + rc_r, 8) + (p7 << 4);

  // operand select for the shared multiplier
  always_comb begin
    is_mul    = 1'b1;
    mul_req.a = ra_r;
    mul_req.b = rc_r;
    case (state_r)
      S_T_MA:  begin mul_req.a = ta;                   mul_req.b = t2;      end
      S_T_MB:  begin mul_req.a = tb;                   mul_req.b = tb;      end
      S_T_MC:  begin mul_req.a = rb_r;                 mul_req.b = t3;      end
      S_P_M1:  begin mul_req.a = rc_r;                 mul_req.b = rc_r;    end
      S_P_M2:  begin mul_req.a = ra_r;                 mul_req.b = p6;      end
      S_P_M3:  begin mul_req.a = rc_r;                 mul_req.b = p5;      end
      S_P_M4:  begin mul_req.a = ra_r;                 mul_req.b = p3;      end
      S_P_M5:  begin mul_req.a = rc_r;                 mul_req.b = p2;      end
      S_P_M6:  begin mul_req.a = ra_r + P_BIAS;        mul_req.b = p1;      end
      S_P_M7:  begin mul_req.a = ra_r;                 mul_req.b = P_SCALE; end
      S_P_M8:  begin mul_req.a = p9;                   mul_req.b = asr(ra_r, 13); end
      S_P_M9:  begin mul_req.a = rb_r;                 mul_req.b = asr(ra_r, 13); end
      S_P_M10: begin mul_req.a = p8;                   mul_req.b = ra_r;    end
      default: is_mul = 1'b0;
    endcase
    mul_req.start = is_mul && !issued_r;
    div_req.start = (state_r == S_P_DIV) && !issued_r;
    div_req.a     = ra_r;
    div_req.b     = rc_r;
  end

  logic in_acc;
  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      issued_r    <= 1'b0;
      ft_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // a word taken downstream frees the register unless a new one loads now
      if (out_valid_r && !out_stall && state_r != S_OUT) out_valid_r <= 1'b0;
      if (mul_req.start || div_req.start) issued_r <= 1'b1;
      if (mul_rsp.done || div_rsp.done) issued_r <= 1'b0;

      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            op_r    <= in_op;
            adc_r   <= in_raw_sample;
            rc_r    <= {{32{ft_r[31]}}, ft_r} - T_OFFSET;
            state_r <= in_op ? S_P_M1 : S_T_MA;
          end
        end
        // temperature
        S_T_MA: if (mul_rsp.done) begin
          ra_r <= asr(mul_rsp.res, 11); state_r <= S_T_MB;
        end
        S_T_MB: if (mul_rsp.done) begin
          rb_r <= asr(mul_rsp.res, 12); state_r <= S_T_MC;
        end
        S_T_MC: if (mul_rsp.done) begin
          ra_r <= ra_r + asr(mul_rsp.res, 14); state_r <= S_T_FIN;
        end
        S_T_FIN: begin
          ft_r        <= ra_r[31:0];
          res_val_r   <= tf5[39:8];
          res_fault_r <= 1'b0;
          state_r     <= S_OUT;
        end
        // pressure: divisor path
        S_P_M1: if (mul_rsp.done) begin
          ra_r <= mul_rsp.res; state_r <= S_P_M2;
        end
        S_P_M2: if (mul_rsp.done) begin
          rb_r <= mul_rsp.res; state_r <= S_P_M3;
        end
        S_P_M3: if (mul_rsp.done) begin
          rb_r    <= rb_r + (mul_rsp.res << 17) + (p4 << 35);
          state_r <= S_P_M4;
        end
        S_P_M4: if (mul_rsp.done) begin
          ra_r <= asr(mul_rsp.res, 8); state_r <= S_P_M5;
        end
        S_P_M5: if (mul_rsp.done) begin
          ra_r <= ra_r + (mul_rsp.res << 12); state_r <= S_P_M6;
        end
        S_P_M6: if (mul_rsp.done) begin
          rc_r <= asr(mul_rsp.res, 33); state_r <= S_P_N;
        end
        S_P_N: begin
          if (rc_r == 64'd0) begin
            res_val_r   <= '0;
            res_fault_r <= 1'b1;
            state_r     <= S_OUT;
          end else begin
            ra_r    <= pn;
            state_r <= S_P_M7;
          end
        end
        // pressure: quotient and correction
        S_P_M7: if (mul_rsp.done) begin
          ra_r <= mul_rsp.res; state_r <= S_P_DIV;
        end
        S_P_DIV: if (div_rsp.done) begin
          ra_r <= div_rsp.res; state_r <= S_P_M8;
        end
        S_P_M8: if (mul_rsp.done) begin
          rb_r <= mul_rsp.res; state_r <= S_P_M9;
        end
        S_P_M9: if (mul_rsp.done) begin
          rb_r <= asr(mul_rsp.res, 25); state_r <= S_P_M10;
        end
        S_P_M10: if (mul_rsp.done) begin
          rc_r <= asr(mul_rsp.res, 19); state_r <= S_P_FIN;
        end
        S_P_FIN: begin
          res_val_r   <= {8'd0, pfin[31:8]};
          res_fault_r <= 1'b0;
          state_r     <= S_OUT;
        end
        // hand the word to the output register once it is free
        S_OUT: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_kind_r  <= op_r;
            out_value_r <= res_val_r;
            out_fault_r <= res_fault_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_value        = $signed(out_value_r);
  assign out_divide_fault = out_fault_r;

endmodule

### tb/sv/tb_baro_temp_pressure_compensation_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_baro_temp_pressure_compensation_top
// checks temperature and pressure compensation words against a local predictor
// ----------------------------------------------------------------------------
// calibration sets are written over the cfg port while the block is idle, then
// directed and random samples are pushed through with random idling on both
// channels; every result word is compared against the predicted one in order
// ----------------------------------------------------------------------------

class comp_scoreboard;
  logic [47:0] cal [4];
  logic [31:0] fine_temp;
  logic        exp_kind [$];
  logic [31:0] exp_value [$];
  logic        exp_fault [$];
  int          mismatches;
  int          checked;
  int          n_temp, n_press, n_fault;

  function new();
    for (int i = 0; i < 4; i++) cal[i] = '0;
    fine_temp  = '0;
    mismatches = 0;
    checked    = 0;
    n_temp = 0;
    n_press = 0;
    n_fault = 0;
  endfunction

  function logic signed [63:0] s16(logic [47:0] r, int pos);
    logic [15:0] w;
    w = r[pos +: 16];
    return {{48{w[15]}}, w};
  endfunction

  function logic signed [63:0] sdiv_trunc(logic [63:0] a, logic [63:0] b);
    logic [63:0] ua, ub, q;
    ua = a[63] ? -a : a;
    ub = b[63] ? -b : b;
    q  = ua / ub;
    return (a[63] != b[63]) ? -q : q;
  endfunction

  // predict one word and queue the expected result
  function void note_sample(logic op, logic [19:0] raw);
    logic signed [63:0] t1, t2, t3, a, b, v1, v2, tf, p;
    logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, hi;
    logic [31:0] val;
    logic        flt;
    val = '0;
    flt = 1'b0;
    if (op == 1'b0) begin
      t1 = {48'd0, cal[0][15:0]};
      t2 = s16(cal[0], 16);
      t3 = s16(cal[0], 32);
      a  = $signed({44'd0, raw}) / 8 - (t1 <<< 1);
      b  = $signed({44'd0, raw}) / 16 - t1;
      v1 = (a * t2) >>> 11;
      v2 = (((b * b) >>> 12) * t3) >>> 14;
      tf = v1 + v2;
      fine_temp = tf[31:0];
      p  = (tf * 5 + 128) >>> 8;
      val = p[31:0];
      n_temp++;
    end else begin
      p1 = {48'd0, cal[1][15:0]};
      p2 = s16(cal[1], 16);
      p3 = s16(cal[1], 32);
      p4 = s16(cal[2], 0);
      p5 = s16(cal[2], 16);
      p6 = s16(cal[2], 32);
      p7 = s16(cal[3], 0);
      p8 = s16(cal[3], 16);
      p9 = s16(cal[3], 32);
      v1 = {{32{fine_temp[31]}}, fine_temp} - 64'sd128000;
      v2 = v1 * v1 * p6;
      v2 = v2 + ((v1 * p5) <<< 17);
      v2 = v2 + (p4 <<< 35);
      v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) <<< 12);
      v1 = (((64'sd1 <<< 47) + v1) * p1) >>> 33;
      if (v1 == 0) begin
        flt = 1'b1;
        n_fault++;
      end else begin
        p  = 64'sd1048576 - $signed({44'd0, raw});
        p  = sdiv_trunc(((p <<< 31) - v2) * 3125, v1);
        hi = p >>> 13;
        v1 = (p9 * hi * hi) >>> 25;
        v2 = (p8 * p) >>> 19;
        p  = ((p + v1 + v2) >>> 8) + (p7 <<< 4);
        val = {8'd0, p[31:8]};
      end
      n_press++;
    end
    exp_kind.push_back(op);
    exp_value.push_back(val);
    exp_fault.push_back(flt);
  endfunction

  function void check_word(logic kind, logic [31:0] value, logic fault);
    logic ek, ef;
    logic [31:0] ev;
    checked++;
    if (exp_kind.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result word kind=%0d value=%0d", kind, value);
      return;
    end
    ek = exp_kind.pop_front();
    ev = exp_value.pop_front();
    ef = exp_fault.pop_front();
    if (ek !== kind || ev !== value || ef !== fault) begin
      mismatches++;
      if (mismatches <= 10)
        $display("word %0d: exp kind=%0d value=%0d fault=%0d, got kind=%0d value=%0d fault=%0d",
                 checked, ek, $signed(ev), ef, kind, $signed(value), fault);
    end
  endfunction

  function int pending();
    return exp_kind.size();
  endfunction
endclass

module tb_baro_temp_pressure_compensation_top;
  import btpc_pkg::*;

  localparam int STALL_LIMIT = 20000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_op = 1'b0;
  logic [19:0] in_raw_sample = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_kind;
  logic signed [31:0] out_value;
  logic        out_divide_fault;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [ADDR_W-1:0] cfg_paddr = '0;
  logic [DATA_W-1:0] cfg_pwdata = '0;
  logic [DATA_W-1:0] cfg_prdata;
  logic        cfg_pready;

  // idle percentages for each channel, changed per phase
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  // long hold-off on the result side, counted in its own process
  int hold_cycles = 0;
  int idle_cycles = 0;
  bit failed = 1'b0;

  comp_scoreboard sb;

  baro_temp_pressure_compensation_top i_dut (.*);

  always #5 clk = ~clk;

  // receiver: random stall, with an optional long hold-off
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // check every accepted result word
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_word(out_kind, out_value, out_divide_fault);
  end

  // watchdog: cycles with no word moving on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // apb write: setup then access cycle
  task automatic write_cal(logic [1:0] idx, logic [47:0] v);
    @(posedge clk);
    cfg_psel   <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr  <= ADDR_W'({idx, 3'b000});
    cfg_pwdata <= {16'hdead ^ 16'($urandom), v};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    sb.cal[idx] = v;
  endtask

  // offer one word and hold it until taken; valid drops at the next idle or drain
  task automatic send_sample(logic op, logic [19:0] raw);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_op         <= op;
    in_raw_sample <= raw;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_sample(op, raw);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  // realistic calibration with small random perturbation
  task automatic cal_typical();
    write_cal(REG_TEMP, {16'(-16'sd1000 + $urandom_range(0, 2000)),
                         16'(26000 + $urandom_range(0, 2000)),
                         16'(27000 + $urandom_range(0, 2000))});
    write_cal(REG_PRESS_A, {16'(-16'sd3000 - $urandom_range(0, 1000)),
                            16'(-16'sd11000 + $urandom_range(0, 1000)),
                            16'(35000 + $urandom_range(0, 3000))});
    write_cal(REG_PRESS_B, {16'(-16'sd7), 16'(-140 + $urandom_range(0, 50)),
                            16'(8000 + $urandom_range(0, 1000))});
    write_cal(REG_PRESS_C, {16'(6000 + $urandom_range(0, 10000)), 16'(-16'sd12000),
                            16'(-10 + $urandom_range(0, 40))});
  endtask

  task automatic cal_random();
    for (int r = 0; r < 4; r++)
      write_cal(r[1:0], {16'($urandom), 16'($urandom), 16'($urandom)});
  endtask

  // mostly plausible temperature then pressure pairs, some noise
  task automatic random_run(int n);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(9) < 7) begin
        send_sample(1'b0, 20'(400000 + $urandom_range(0, 200000)));
        send_sample(1'b1, 20'(250000 + $urandom_range(0, 200000)));
        k++;
      end else begin
        send_sample(1'($urandom), 20'($urandom));
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // pressure before any temperature: divisor is zero with zero calibration
    send_sample(1'b1, 20'd0);
    send_sample(1'b0, 20'hfffff);
    drain();

    // all-ones calibration extremes
    for (int r = 0; r < 4; r++) write_cal(r[1:0], 48'hffff_ffff_ffff);
    send_sample(1'b0, 20'd0);
    send_sample(1'b1, 20'd0);
    send_sample(1'b0, 20'hfffff);
    send_sample(1'b1, 20'hfffff);
    drain();
    // signed extremes
    write_cal(REG_TEMP, 48'h8000_7fff_ffff);
    write_cal(REG_PRESS_A, 48'h7fff_8000_ffff);
    write_cal(REG_PRESS_B, 48'h8000_7fff_8000);
    write_cal(REG_PRESS_C, 48'h7fff_8000_7fff);
    send_sample(1'b0, 20'h80000);
    send_sample(1'b1, 20'h7ffff);
    send_sample(1'b1, 20'h00001);
    drain();
    cal_typical();
    send_sample(1'b0, 20'd519888);
    send_sample(1'b1, 20'd415148);
    send_sample(1'b1, 20'hfffff);
    send_sample(1'b0, 20'h55555);
    send_sample(1'b1, 20'haaaaa);
    drain();

    // pressure calibration with P1 zero forces a divide fault
    write_cal(REG_PRESS_A, 48'h1234_5678_0000);
    send_sample(1'b0, 20'd500000);
    send_sample(1'b1, 20'd300000);
    drain();

    // phase one: sender idles 35%, receiver 67%
    send_idle_pct = 35; recv_idle_pct = 67;
    cal_typical();
    random_run(150);
    drain();

    // long hold-off on the result side while inputs keep coming
    hold_cycles = 1500;
    random_run(10);
    drain();

    // phase two: the other way round
    send_idle_pct = 67; recv_idle_pct = 35;
    cal_random();
    random_run(60);
    drain();
    cal_typical();
    random_run(90);
    drain();

    // phase three: no idling
    send_idle_pct = 0; recv_idle_pct = 0;
    cal_typical();
    random_run(120);
    drain();

    if (sb.mismatches > 0 || sb.pending() > 0) failed = 1'b1;
    $display("covered %0d temperature and %0d pressure words (%0d divide faults)",
             sb.n_temp, sb.n_press, sb.n_fault);
    $display("%0d result words checked, %0d mismatches", sb.checked, sb.mismatches);
    if (!failed) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
